// File: rtl/sdrc_pkg.sv
// Shared types, constants and CRC7 helpers for the SD sequential read command generator.
`default_nettype none

package sdrc_pkg;

  // Command frame layout
  localparam int unsigned FRAME_W    = 48;
  localparam int unsigned HEAD_W     = 40;
  localparam int unsigned ARG_W      = 32;
  localparam int unsigned CRC_W      = 7;
  localparam int unsigned BLOCK_SHIFT = 9;

  localparam logic [7:0] CMD_START_BITS = 8'h40;
  localparam logic [7:0] CMD_STOP       = 8'd12;
  localparam logic [7:0] CMD_READ_MULTI = 8'd18;
  localparam logic [7:0] STOP_CRC_BYTE  = 8'h61;
  localparam logic [CRC_W-1:0] CRC7_POLY = 7'h09;

  // Stop frame is fixed: CMD12, zero argument, fixed CRC byte
  localparam logic [FRAME_W-1:0] STOP_FRAME =
    {(CMD_START_BITS | CMD_STOP), {ARG_W{1'b0}}, STOP_CRC_BYTE};
  localparam logic [7:0] READ_INDEX_BYTE = CMD_START_BITS | CMD_READ_MULTI;

  // Action codes
  localparam logic ACT_CONTINUE = 1'b0;
  localparam logic ACT_ISSUE    = 1'b1;

  // Register word addresses (byte address bits above the word offset)
  localparam logic REG_BLOCK_ADDRESSING = 1'b0;

  // Decoded request handed from the accept stage to the frame stage
  typedef struct packed {
    logic             cont;  // continue the running stream
    logic             stop;  // issue a stop frame before the read frame
    logic [ARG_W-1:0] arg;   // read command argument
  } req_t;

  // CRC7 contribution of a single set bit at position pos of the 40-bit head.
  // Only ever called with constant positions, so it folds at elaboration.
  function automatic logic [CRC_W-1:0] crc7_column(input int unsigned pos);
    logic [CRC_W-1:0] crc;
    logic             fb;
    crc = '0;
    for (int i = HEAD_W - 1; i >= 0; i--) begin
      fb  = crc[CRC_W-1] ^ (i == int'(pos));
      crc = {crc[CRC_W-2:0], 1'b0};
      if (fb) begin
        crc = crc ^ CRC7_POLY;
      end
    end
    return crc;
  endfunction

  // CRC7 of a 40-bit head: XOR of the columns of its set bits
  function automatic logic [CRC_W-1:0] crc7_of_head(input logic [HEAD_W-1:0] head);
    logic [CRC_W-1:0] crc;
    crc = '0;
    for (int unsigned i = 0; i < HEAD_W; i++) begin
      if (head[i]) begin
        crc = crc ^ crc7_column(i);
      end
    end
    return crc;
  endfunction

endpackage

`default_nettype wire

// File: rtl/sd_sequential_read_command_gen.sv
// Top level: configuration register, stream tracking and the frame output stage.
//
//   channel  direction  handshake            word
//   in       to block   in_valid / in_stall   block_number
//   out      from block out_valid / out_stall action, command_frame, last
//   config   to block   APB write/read        block_addressing at byte address 0
//
// A request is taken every cycle when it yields one word and the output is not
// stalled; a request that needs a stop frame first occupies the request register
// until both its words have gone out. A request passes the request register, then
// the result register, where the CRC7 is folded in.
// Synchronous reset clears the valid flags, the stream state and block_addressing.
// out_stall backs up into in_stall only once both registers hold words.
`default_nettype none

module sd_sequential_read_command_gen
  import sdrc_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  // APB configuration port
  input  wire logic                 psel,
  input  wire logic                 penable,
  input  wire logic                 pwrite,
  input  wire logic [2:0]           paddr,
  input  wire logic [31:0]          pwdata,
  output logic [31:0]               prdata,
  output logic                      pready,
  // request channel
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [ARG_W-1:0]     block_number,
  // result channel
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic                      action,
  output logic [FRAME_W-1:0]        command_frame,
  output logic                      last
);

  logic             block_addressing;
  logic             transfer_active;
  logic [ARG_W-1:0] previous_block;
  logic             in_accept;
  logic             is_next;
  req_t             req;

  assign pready = 1'b1;

  // Register read-back
  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_BLOCK_ADDRESSING) begin
      prdata[0] = block_addressing;
    end
  end

  // Configuration write
  always_ff @(posedge clk) begin
    if (rst) begin
      block_addressing <= 1'b0;
    end else if (psel && penable && pwrite && paddr[2] == REG_BLOCK_ADDRESSING) begin
      block_addressing <= pwdata[0];
    end
  end

  // Decode the request against the running stream
  assign in_accept = in_valid && !in_stall;
  assign is_next   = previous_block == (block_number - ARG_W'(1));
  assign req.cont  = transfer_active && is_next;
  assign req.stop  = transfer_active && !is_next;
  assign req.arg   = block_addressing ? block_number : (block_number << BLOCK_SHIFT);

  // Track the stream on every accepted request
  always_ff @(posedge clk) begin
    if (rst) begin
      transfer_active <= 1'b0;
      previous_block  <= '0;
    end else if (in_accept) begin
      transfer_active <= 1'b1;
      previous_block  <= block_number;
    end
  end

  sdrc_frame_stage u_frame_stage (
    .clk           (clk),
    .rst           (rst),
    .req_valid     (in_valid),
    .req           (req),
    .req_stall     (in_stall),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .action        (action),
    .command_frame (command_frame),
    .last          (last)
  );

endmodule

`default_nettype wire

// File: rtl/sdrc_frame_stage.sv
// Request register and result register that expand one request into its command frames.
`default_nettype none

module sdrc_frame_stage
  import sdrc_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               req_valid,
  input  wire req_t               req,
  output logic                    req_stall,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic                    action,
  output logic [FRAME_W-1:0]      command_frame,
  output logic                    last
);

  logic               hold_valid;
  req_t               hold;
  logic               out_free;
  logic               hold_final;
  logic               hold_done;
  logic               load_hold;
  logic [HEAD_W-1:0]  read_head;
  logic [FRAME_W-1:0] read_frame;
  logic               action_next;
  logic [FRAME_W-1:0] frame_next;
  logic               last_next;

  // Handshake between the request register and the result register
  assign out_free   = !out_valid || !out_stall;
  assign hold_final = hold.cont || !hold.stop;
  assign hold_done  = hold_valid && out_free && hold_final;
  assign load_hold  = !hold_valid || hold_done;
  assign req_stall  = !load_hold;

  // Build the read frame with its CRC7 and end bit
  assign read_head  = {READ_INDEX_BYTE, hold.arg};
  assign read_frame = {read_head, crc7_of_head(read_head), 1'b1};

  // Select the word to present next
  always_comb begin
    if (hold.cont) begin
      action_next = ACT_CONTINUE;
      frame_next  = '0;
      last_next   = 1'b1;
    end else if (hold.stop) begin
      action_next = ACT_ISSUE;
      frame_next  = STOP_FRAME;
      last_next   = 1'b0;
    end else begin
      action_next = ACT_ISSUE;
      frame_next  = read_frame;
      last_next   = 1'b1;
    end
  end

  // Control: valid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (out_free) begin
        out_valid <= hold_valid;
      end
      if (load_hold) begin
        hold_valid <= req_valid;
      end
    end
  end

  // Payload: request register and result word
  always_ff @(posedge clk) begin
    if (out_free && hold_valid) begin
      action        <= action_next;
      command_frame <= frame_next;
      last          <= last_next;
    end
    if (load_hold) begin
      hold <= req;
    end else if (out_free && !hold_final) begin
      // stop frame went out; the read frame follows from the same request
      hold.stop <= 1'b0;
    end
  end

endmodule

`default_nettype wire

// File: tb/sd_sequential_read_command_gen_test.sv
// Self-checking testbench for the SD sequential read command generator.
`default_nettype none

module sd_sequential_read_command_gen_test
  import sdrc_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned DRAIN_CYCLES = 6;

  // One output word of the block
  typedef struct packed {
    logic               action;
    logic [FRAME_W-1:0] frame;
    logic               last;
  } cmd_word_t;

  // Tracks stream state and the command words the block owes us
  class read_cmd_tracker;
    bit              addr_by_block;
    bit              streaming;
    logic [ARG_W-1:0] prev_block;
    cmd_word_t       owed[$];
    int              errors;
    int              n_cont;
    int              n_stop;
    int              n_read;

    function new();
      addr_by_block = 1'b0;
      streaming = 1'b0;
      prev_block = '0;
      errors = 0;
      n_cont = 0;
      n_stop = 0;
      n_read = 0;
    endfunction

    // Serial CRC7 over the 40-bit head, MSB first
    function automatic logic [6:0] head_crc7(logic [39:0] head);
      logic [6:0] crc;
      logic       fb;
      crc = '0;
      for (int i = 39; i >= 0; i--) begin
        fb = crc[6] ^ head[i];
        crc = {crc[5:0], 1'b0};
        if (fb) begin
          crc = crc ^ CRC7_POLY;
        end
      end
      return crc;
    endfunction

    // Work out the words one accepted block request produces
    function void note_block(logic [ARG_W-1:0] blk);
      cmd_word_t        w;
      logic [ARG_W-1:0] arg;
      logic [39:0]      head;
      if (streaming && blk == prev_block + 32'd1) begin
        w.action = ACT_CONTINUE;
        w.frame = '0;
        w.last = 1'b1;
        owed.push_back(w);
        prev_block = blk;
        return;
      end
      if (streaming) begin
        w.action = ACT_ISSUE;
        w.frame = {(CMD_START_BITS | CMD_STOP), 32'h0, STOP_CRC_BYTE};
        w.last = 1'b0;
        owed.push_back(w);
      end
      arg = addr_by_block ? blk : (blk << BLOCK_SHIFT);
      head = {(CMD_START_BITS | CMD_READ_MULTI), arg};
      w.action = ACT_ISSUE;
      w.frame = {head, head_crc7(head), 1'b1};
      w.last = 1'b1;
      owed.push_back(w);
      prev_block = blk;
      streaming = 1'b1;
    endfunction

    // Compare one delivered word with the oldest owed one
    function void check_word(cmd_word_t got);
      cmd_word_t want;
      if (owed.size() == 0) begin
        $error("unexpected word: action %h frame %h last %h",
               got.action, got.frame, got.last);
        errors++;
        return;
      end
      want = owed.pop_front();
      if (got.action !== want.action) begin
        $error("action: expected %h, got %h", want.action, got.action);
        errors++;
      end
      if (got.frame !== want.frame) begin
        $error("command_frame: expected %h, got %h", want.frame, got.frame);
        errors++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %h, got %h", want.last, got.last);
        errors++;
      end
      if (want.action == ACT_CONTINUE) n_cont++;
      else if (want.last) n_read++;
      else n_stop++;
    endfunction

    function int pending();
      return owed.size();
    endfunction
  endclass

  logic               clk;
  logic               rst;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [2:0]         paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;
  logic               in_valid;
  logic               in_stall;
  logic [ARG_W-1:0]   block_number;
  logic               out_valid;
  logic               out_stall;
  logic               action;
  logic [FRAME_W-1:0] command_frame;
  logic               last;

  read_cmd_tracker tracker = new();

  int unsigned      cycles = 0;
  int unsigned      tx_idle_pct = 0;
  int unsigned      rx_idle_pct = 0;
  int unsigned      hold_left = 0;
  int unsigned      n_requests = 0;
  logic [ARG_W-1:0] last_sent = '0;

  sd_sequential_read_command_gen DUT (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .block_number  (block_number),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .action        (action),
    .command_frame (command_frame),
    .last          (last)
  );

  // 4 ns clock
  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Check every word the block hands over
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      tracker.check_word({action, command_frame, last});
    end
  end

  // Drive receiver stall: long hold-off when requested, else random
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_stall = 1'b1;
      hold_left--;
    end else begin
      out_stall = ($urandom_range(99) < rx_idle_pct);
    end
  end

  // Offer one word and hold it until taken; returns at a falling edge with valid low
  task automatic send_block(logic [ARG_W-1:0] blk);
    // idle each cycle with the set probability before offering
    while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    block_number = blk;
    do @(posedge clk); while (in_stall);
    tracker.note_block(blk);
    last_sent = blk;
    n_requests++;
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  // Stop offering and wait until every owed word has arrived
  task automatic drain();
    in_valid = 1'b0;
    while (tracker.pending() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // APB write of block_addressing; junk in the upper bits must be ignored
  task automatic write_addressing(bit mode);
    psel = 1'b1;
    pwrite = 1'b1;
    penable = 1'b0;
    paddr = {REG_BLOCK_ADDRESSING, 2'b00};
    pwdata = {$urandom_range(1) ? 31'($urandom) : 31'h0, mode};
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    tracker.addr_by_block = mode;
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  // Mostly sequential runs, with restarts, jumps back and wrap-around cases
  function automatic logic [ARG_W-1:0] pick_block(logic [ARG_W-1:0] prev);
    int unsigned r;
    r = $urandom_range(99);
    if (r < 55) return prev + 32'd1;
    if (r < 63) return prev;
    if (r < 70) return prev - 32'($urandom_range(1, 8));
    if (r < 78) return 32'($urandom_range(15));
    if (r < 85) return 32'hFFFF_FFFF - 32'($urandom_range(3));
    if (r < 90) return 32'h007F_FFFF + 32'($urandom_range(2));
    return $urandom;
  endfunction

  task automatic run_random(int unsigned count);
    for (int unsigned i = 0; i < count; i++) begin
      send_block(pick_block(last_sent));
    end
  endtask

  initial begin
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_valid = 1'b0;
    block_number = '0;
    out_stall = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed, byte addressing: start, continue, wrap, restart, overflow
    write_addressing(1'b0);
    send_block(32'h0000_0000);
    send_block(32'h0000_0001);
    send_block(32'h0000_0002);
    send_block(32'hFFFF_FFFF);
    send_block(32'h0000_0000);
    send_block(32'h0000_0000);
    send_block(32'h0000_0005);
    send_block(32'h0000_0003);
    send_block(32'h007F_FFFF);
    send_block(32'h0080_0000);
    send_block(32'hAAAA_AAAA);
    send_block(32'h5555_5555);
    drain();

    // Directed, block addressing
    write_addressing(1'b1);
    send_block(32'hFFFF_FFFE);
    send_block(32'hFFFF_FFFF);
    send_block(32'h0000_0000);
    send_block(32'h1234_5678);
    send_block(32'h8000_0000);
    send_block(32'h8000_0001);
    send_block(32'h7FFF_FFFF);
    send_block(32'h5555_5555);
    send_block(32'hAAAA_AAAA);
    send_block(32'hAAAA_AAAB);
    drain();

    // Random, sender idles less than receiver
    write_addressing(1'b0);
    tx_idle_pct = 30;
    rx_idle_pct = 46;
    run_random(250);
    drain();

    // Random, receiver idles less than sender
    write_addressing(1'b1);
    tx_idle_pct = 46;
    rx_idle_pct = 30;
    run_random(125);
    drain();
    run_random(125);
    drain();

    // Full rate, with a long receiver hold-off to back up the input
    write_addressing(1'b0);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    run_random(100);
    @(posedge clk);
    hold_left = 80;
    @(negedge clk);
    run_random(60);
    drain();
    write_addressing(1'b1);
    run_random(100);
    drain();

    $display("Ran %0d block requests in both addressing modes under mixed stalls.",
             n_requests);
    $display("Checked %0d continue words, %0d stop frames, %0d read frames.",
             tracker.n_cont, tracker.n_stop, tracker.n_read);
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
